[hw/rtl/blc_pkg.sv]
// ---------------------------------------------------------------------------
// blc_pkg
// Shared constants for the 3d box line clipper: widths, register indexes.
// ---------------------------------------------------------------------------
package blc_pkg;

    localparam int BLC_COORD_WIDTH   = 32;
    localparam int BLC_FRACTION_BITS = 16;
    // fraction bits of the line parameter t, range 0 to 1.0 inclusive
    localparam int BLC_T_FRAC        = 32;
    localparam int BLC_IDX_W         = 3;

    localparam logic [BLC_IDX_W-1:0] REG_X_LOW  = 3'd0;
    localparam logic [BLC_IDX_W-1:0] REG_X_HIGH = 3'd1;
    localparam logic [BLC_IDX_W-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [BLC_IDX_W-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [BLC_IDX_W-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [BLC_IDX_W-1:0] REG_Z_HIGH = 3'd5;

endpackage

[hw/rtl/blc_in_if.sv]
// ---------------------------------------------------------------------------
// blc_in_if
// Segment input channel: valid/ready handshake and two endpoints.
// ---------------------------------------------------------------------------
interface blc_in_if #(
    parameter int W = blc_pkg::BLC_COORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] start_x_in;
    logic signed [W-1:0] start_y_in;
    logic signed [W-1:0] start_z_in;
    logic signed [W-1:0] end_x_in;
    logic signed [W-1:0] end_y_in;
    logic signed [W-1:0] end_z_in;

    modport source (
        output valid, start_x_in, start_y_in, start_z_in, end_x_in, end_y_in, end_z_in,
        input  ready
    );
    modport sink (
        input  valid, start_x_in, start_y_in, start_z_in, end_x_in, end_y_in, end_z_in,
        output ready
    );
endinterface

[hw/rtl/blc_out_if.sv]
// ---------------------------------------------------------------------------
// blc_out_if
// Clipped segment output channel: valid/ready handshake, visible flag, endpoints.
// ---------------------------------------------------------------------------
interface blc_out_if #(
    parameter int W = blc_pkg::BLC_COORD_WIDTH
);
    logic                valid;
    logic                ready;
    logic                visible;
    logic signed [W-1:0] start_x_out;
    logic signed [W-1:0] start_y_out;
    logic signed [W-1:0] start_z_out;
    logic signed [W-1:0] end_x_out;
    logic signed [W-1:0] end_y_out;
    logic signed [W-1:0] end_z_out;

    modport source (
        output valid, visible, start_x_out, start_y_out, start_z_out,
               end_x_out, end_y_out, end_z_out,
        input  ready
    );
    modport sink (
        input  valid, visible, start_x_out, start_y_out, start_z_out,
               end_x_out, end_y_out, end_z_out,
        output ready
    );
endinterface

[hw/rtl/blc_tdiv.sv]
// ---------------------------------------------------------------------------
// blc_tdiv
// Pipelined restoring divider, one quotient bit per stage: q = floor(a*2^T/b).
// ---------------------------------------------------------------------------
module blc_tdiv #(
    parameter int DW = blc_pkg::BLC_COORD_WIDTH + 2
) (
    input  logic                          i_clk,
    input  logic [blc_pkg::BLC_T_FRAC:0]  i_en,
    input  logic [DW-1:0]                 i_a,
    input  logic [DW-1:0]                 i_b,
    output logic [blc_pkg::BLC_T_FRAC:0]  o_q
);
    import blc_pkg::*;

    localparam int NS = BLC_T_FRAC + 1;

    logic [DW-1:0] r_rem [NS];
    logic [DW-1:0] r_den [NS];
    logic [NS-1:0] r_quo [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [DW:0]   n_sh;
        logic [DW-1:0] n_den;
        logic [NS-1:0] n_prev;
        logic [DW-1:0] n_rem;
        logic [NS-1:0] n_quo;

        if (j == 0) begin : g_first
            assign n_sh   = {1'b0, i_a};
            assign n_den  = i_b;
            assign n_prev = '0;
        end else begin : g_next
            assign n_sh   = {r_rem[j-1], 1'b0};
            assign n_den  = r_den[j-1];
            assign n_prev = r_quo[j-1];
        end

        always_comb begin
            if (n_sh >= {1'b0, n_den}) begin
                n_rem = DW'(n_sh - {1'b0, n_den});
                n_quo = {n_prev[NS-2:0], 1'b1};
            end else begin
                n_rem = DW'(n_sh);
                n_quo = {n_prev[NS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem;
                r_den[j] <= n_den;
                r_quo[j] <= n_quo;
            end
        end
    end

    assign o_q = r_quo[NS-1];

endmodule

[hw/rtl/blc_tscale.sv]
// ---------------------------------------------------------------------------
// blc_tscale
// Pipelined shift-and-add scaler, one bit of t per stage: floor(m*t/2^T).
// ---------------------------------------------------------------------------
module blc_tscale #(
    parameter int MW = blc_pkg::BLC_COORD_WIDTH + 1
) (
    input  logic                          i_clk,
    input  logic [blc_pkg::BLC_T_FRAC:0]  i_en,
    input  logic [MW-1:0]                 i_m,
    input  logic [blc_pkg::BLC_T_FRAC:0]  i_t,
    output logic [MW:0]                   o_off
);
    import blc_pkg::*;

    localparam int NS = BLC_T_FRAC + 1;

    logic [MW:0]   r_acc [NS];
    logic [MW-1:0] r_m   [NS];
    logic [NS-1:0] r_t   [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [MW:0]   n_prev;
        logic [MW-1:0] n_m;
        logic [NS-1:0] n_t;
        logic [MW:0]   n_sum;

        if (j == 0) begin : g_first
            assign n_prev = '0;
            assign n_m    = i_m;
            assign n_t    = i_t;
        end else begin : g_next
            assign n_prev = r_acc[j-1];
            assign n_m    = r_m[j-1];
            assign n_t    = r_t[j-1];
        end

        assign n_sum = n_prev + (n_t[j] ? {1'b0, n_m} : '0);

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                // the integer bit of t is added without the halving
                r_acc[j] <= (j == NS - 1) ? n_sum : (n_sum >> 1);
                r_m[j]   <= n_m;
                r_t[j]   <= n_t;
            end
        end
    end

    assign o_off = r_acc[NS-1];

endmodule

[hw/rtl/box_line_clipper_3d_unit.sv]
// throughput: one segment per cycle while the output is not stalled, with 33-stage t dividers and scalers
// each stage holds its word while the next stage is full and held; bubbles are squeezed out
// reset: clears all stage valid bits and loads the default box (5 x 4 x 3)
// ---------------------------------------------------------------------------
// box_line_clipper_3d_unit
// Clips a 3d segment against an axis-aligned box held in six registers.
// ---------------------------------------------------------------------------
module box_line_clipper_3d_unit #(
    parameter int W  = blc_pkg::BLC_COORD_WIDTH,
    parameter int FB = blc_pkg::BLC_FRACTION_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [blc_pkg::BLC_IDX_W-1:0]   i_cfg_idx,
    input  logic [W-1:0]                    i_cfg_data,
    blc_in_if.sink                          i_seg,
    blc_out_if.source                       o_seg
);
    import blc_pkg::*;

    localparam int NS     = BLC_T_FRAC + 1;
    localparam int DW     = W + 2;
    localparam int MW     = W + 1;
    localparam int ST_S   = 0;
    localparam int ST_AB  = 1;
    localparam int ST_DIV = 2;
    localparam int ST_SEL = ST_DIV + NS;
    localparam int ST_CHK = ST_SEL + 1;
    localparam int ST_SCL = ST_CHK + 1;
    localparam int ST_OUT = ST_SCL + NS;
    localparam int NST    = ST_OUT + 1;

    localparam logic [W-1:0]  RST_X_HIGH = W'(64'd5 << FB);
    localparam logic [W-1:0]  RST_Y_HIGH = W'(64'd4 << FB);
    localparam logic [W-1:0]  RST_Z_HIGH = W'(64'd3 << FB);
    localparam logic [NS-1:0] T_ONE      = {1'b1, {BLC_T_FRAC{1'b0}}};

    typedef struct packed {
        logic [2:0][W-1:0] p0;
        logic [2:0][W-1:0] p1;
        logic              rej;
        logic [5:0]        ent;
        logic [5:0]        ext;
    } t_ctx;

    // box registers
    logic [W-1:0] r_bound [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound[0] <= '0;
            r_bound[1] <= RST_X_HIGH;
            r_bound[2] <= '0;
            r_bound[3] <= RST_Y_HIGH;
            r_bound[4] <= '0;
            r_bound[5] <= RST_Z_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_X_LOW:  r_bound[0] <= i_cfg_data;
                REG_X_HIGH: r_bound[1] <= i_cfg_data;
                REG_Y_LOW:  r_bound[2] <= i_cfg_data;
                REG_Y_HIGH: r_bound[3] <= i_cfg_data;
                REG_Z_LOW:  r_bound[4] <= i_cfg_data;
                REG_Z_HIGH: r_bound[5] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // stage control
    logic [NST-1:0] r_vld;
    logic [NST:0]   en;
    t_ctx           r_ctx [NST];
    t_ctx           n_ctx [NST];

    always_comb begin
        en[NST] = o_seg.ready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_seg.ready = en[0];

    // stage payload signals
    logic signed [W:0] r_s0 [6];
    logic signed [W:0] r_s1 [6];
    logic [DW-1:0]     r_a  [6];
    logic [DW-1:0]     r_b  [6];
    logic [NS-1:0]     w_q  [6];
    logic [5:0]        n_ent, n_ext;
    logic              n_rej;
    logic [NS-1:0]     r_tin, r_tout, n_tin, n_tout;
    logic [NS-1:0]     r_tin2, r_tout2;
    logic [MW-1:0]     r_m   [3];
    logic [2:0]        r_neg;
    logic [MW:0]       w_off_s [3];
    logic [MW:0]       w_off_e [3];
    logic              r_vis;
    logic [W-1:0]      r_res_s [3];
    logic [W-1:0]      r_res_e [3];

    // context pipeline
    for (genvar k = 0; k < NST; k++) begin : g_ctx
        if (k == ST_S) begin : g_in
            always_comb begin
                n_ctx[k].p0  = {i_seg.start_z_in, i_seg.start_y_in, i_seg.start_x_in};
                n_ctx[k].p1  = {i_seg.end_z_in, i_seg.end_y_in, i_seg.end_x_in};
                n_ctx[k].rej = 1'b0;
                n_ctx[k].ent = '0;
                n_ctx[k].ext = '0;
            end
        end else if (k == ST_AB) begin : g_ab
            always_comb begin
                n_ctx[k]     = r_ctx[k-1];
                n_ctx[k].rej = n_rej;
                n_ctx[k].ent = n_ent;
                n_ctx[k].ext = n_ext;
            end
        end else if (k == ST_CHK) begin : g_chk
            always_comb begin
                n_ctx[k]     = r_ctx[k-1];
                // entry after exit leaves nothing inside
                n_ctx[k].rej = r_ctx[k-1].rej || (r_tin > r_tout);
            end
        end else begin : g_pass
            assign n_ctx[k] = r_ctx[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= (k == ST_S) ? i_seg.valid : r_vld[(k == 0) ? 0 : k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_ctx[k] <= n_ctx[k];
            end
        end
    end

    // stage 0: signed inside distances for the six faces
    always_ff @(posedge i_clk) begin
        if (en[ST_S]) begin
            for (int f = 0; f < 6; f++) begin
                if ((f % 2) == 0) begin
                    r_s0[f] <= {n_ctx[ST_S].p0[f/2][W-1], n_ctx[ST_S].p0[f/2]}
                             - {r_bound[f][W-1], r_bound[f]};
                    r_s1[f] <= {n_ctx[ST_S].p1[f/2][W-1], n_ctx[ST_S].p1[f/2]}
                             - {r_bound[f][W-1], r_bound[f]};
                end else begin
                    r_s0[f] <= {r_bound[f][W-1], r_bound[f]}
                             - {n_ctx[ST_S].p0[f/2][W-1], n_ctx[ST_S].p0[f/2]};
                    r_s1[f] <= {r_bound[f][W-1], r_bound[f]}
                             - {n_ctx[ST_S].p1[f/2][W-1], n_ctx[ST_S].p1[f/2]};
                end
            end
        end
    end

    // stage 1: face class and divider operands
    always_comb begin
        n_rej = 1'b0;
        for (int f = 0; f < 6; f++) begin
            n_ent[f] = r_s0[f][W] && !r_s1[f][W];
            n_ext[f] = !r_s0[f][W] && r_s1[f][W];
            n_rej    = n_rej || (r_s0[f][W] && r_s1[f][W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_AB]) begin
            for (int f = 0; f < 6; f++) begin
                if (n_ent[f]) begin
                    r_a[f] <= DW'(-{r_s0[f][W], r_s0[f]});
                    r_b[f] <= DW'({r_s1[f][W], r_s1[f]} - {r_s0[f][W], r_s0[f]});
                end else if (n_ext[f]) begin
                    r_a[f] <= DW'({r_s0[f][W], r_s0[f]});
                    r_b[f] <= DW'({r_s0[f][W], r_s0[f]} - {r_s1[f][W], r_s1[f]});
                end else begin
                    // no limit from this face: any nonzero divisor will do
                    r_a[f] <= '0;
                    r_b[f] <= DW'(1);
                end
            end
        end
    end

    for (genvar f = 0; f < 6; f++) begin : g_div
        blc_tdiv #(.DW(DW)) u_div (
            .i_clk (i_clk),
            .i_en  (en[ST_DIV+NS-1:ST_DIV]),
            .i_a   (r_a[f]),
            .i_b   (r_b[f]),
            .o_q   (w_q[f])
        );
    end

    // largest entry and smallest exit
    always_comb begin
        n_tin  = '0;
        n_tout = T_ONE;
        for (int f = 0; f < 6; f++) begin
            if (r_ctx[ST_SEL-1].ent[f] && (w_q[f] > n_tin)) begin
                n_tin = w_q[f];
            end
            if (r_ctx[ST_SEL-1].ext[f] && (w_q[f] < n_tout)) begin
                n_tout = w_q[f];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SEL]) begin
            r_tin  <= n_tin;
            r_tout <= n_tout;
        end
    end

    // direction magnitude and sign per axis
    always_ff @(posedge i_clk) begin
        if (en[ST_CHK]) begin
            r_tin2  <= r_tin;
            r_tout2 <= r_tout;
            for (int a = 0; a < 3; a++) begin
                logic signed [W:0] d;
                d = {r_ctx[ST_CHK-1].p1[a][W-1], r_ctx[ST_CHK-1].p1[a]}
                  - {r_ctx[ST_CHK-1].p0[a][W-1], r_ctx[ST_CHK-1].p0[a]};
                r_neg[a] <= d[W];
                r_m[a]   <= d[W] ? MW'(-d) : MW'(d);
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_scl
        blc_tscale #(.MW(MW)) u_scl_s (
            .i_clk (i_clk),
            .i_en  (en[ST_SCL+NS-1:ST_SCL]),
            .i_m   (r_m[a]),
            .i_t   (r_tin2),
            .o_off (w_off_s[a])
        );
        blc_tscale #(.MW(MW)) u_scl_e (
            .i_clk (i_clk),
            .i_en  (en[ST_SCL+NS-1:ST_SCL]),
            .i_m   (r_m[a]),
            .i_t   (r_tout2),
            .o_off (w_off_e[a])
        );
    end

    // sign of each axis rides along with the scaler stages
    logic [2:0] r_neg_d [NS];

    for (genvar j = 0; j < NS; j++) begin : g_neg
        always_ff @(posedge i_clk) begin
            if (en[ST_SCL+j]) begin
                r_neg_d[j] <= (j == 0) ? r_neg : r_neg_d[(j == 0) ? 0 : j-1];
            end
        end
    end

    // output word: offset from the original start point, or the original endpoints when rejected
    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_vis <= !r_ctx[ST_OUT-1].rej;
            for (int a = 0; a < 3; a++) begin
                logic signed [W+1:0] p;
                p = {{2{r_ctx[ST_OUT-1].p0[a][W-1]}}, r_ctx[ST_OUT-1].p0[a]};
                if (r_ctx[ST_OUT-1].rej) begin
                    r_res_s[a] <= r_ctx[ST_OUT-1].p0[a];
                    r_res_e[a] <= r_ctx[ST_OUT-1].p1[a];
                end else if (r_neg_d[NS-1][a]) begin
                    r_res_s[a] <= W'(p - w_off_s[a]);
                    r_res_e[a] <= W'(p - w_off_e[a]);
                end else begin
                    r_res_s[a] <= W'(p + w_off_s[a]);
                    r_res_e[a] <= W'(p + w_off_e[a]);
                end
            end
        end
    end

    assign o_seg.valid       = r_vld[NST-1];
    assign o_seg.visible     = r_vis;
    assign o_seg.start_x_out = r_res_s[0];
    assign o_seg.start_y_out = r_res_s[1];
    assign o_seg.start_z_out = r_res_s[2];
    assign o_seg.end_x_out   = r_res_e[0];
    assign o_seg.end_y_out   = r_res_e[1];
    assign o_seg.end_z_out   = r_res_e[2];

`ifndef SYNTH
    a_no_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en[0] |-> (r_vld[NST-1] && !o_seg.ready))
        else $error("input blocked while pipeline can move");

    a_tin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_SEL] |-> (r_tin <= T_ONE && r_tout <= T_ONE))
        else $error("line parameter above one");

    a_visible_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_CHK] && !r_ctx[ST_CHK].rej) |-> (r_tin2 <= r_tout2))
        else $error("visible word with entry after exit");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST-1] && !o_seg.ready) |=> (r_vld[NST-1] && $stable(r_vis)))
        else $error("stalled output word changed");
`endif

endmodule

[test/box_line_clipper_3d_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_line_clipper_3d_unit_test
// Drives 3d segments through the box clipper under several box settings and
// random idling on both channels, and compares every clipped word with a
// local fixed-point clipper.
// ---------------------------------------------------------------------------
module box_line_clipper_3d_unit_test;
    import blc_pkg::*;

    localparam int W          = BLC_COORD_WIDTH;
    localparam int TF         = BLC_T_FRAC;
    localparam int LIMIT      = 600000;
    localparam int DRAIN      = 80;
    localparam logic [BLC_IDX_W-1:0] REG_SPARE = 3'd6;

    typedef struct packed {
        logic signed [W-1:0] sx, sy, sz, ex, ey, ez;
    } t_seg;

    typedef struct packed {
        logic                visible;
        logic signed [W-1:0] sx, sy, sz, ex, ey, ez;
    } t_clip;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [BLC_IDX_W-1:0] i_cfg_idx;
    logic [W-1:0]         i_cfg_data;

    blc_in_if  #(.W(W)) seg_in ();
    blc_out_if #(.W(W)) seg_out ();

    box_line_clipper_3d_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_seg      (seg_in.sink),
        .o_seg      (seg_out.source)
    );

    logic signed [W-1:0] box_bound [6];
    t_clip               clip_expected [$];
    int                  mismatches;
    int                  cycle_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("box_line_clipper_3d_unit verification failed");
            $finish;
        end
    end

    // ---- clipper model ----
    function automatic logic [TF:0] t_ratio(longint unsigned a, longint unsigned b);
        logic [127:0] num;
        num = {64'd0, a} << TF;
        return (TF+1)'(num / {64'd0, b});
    endfunction

    function automatic logic [W-1:0] point_on(longint p0, longint p1, logic [TF:0] t);
        longint       d;
        logic [127:0] prod;
        longint       off;
        d    = p1 - p0;
        prod = 128'(d < 0 ? -d : d) * 128'(t);
        off  = longint'(prod >> TF);
        return W'(d < 0 ? p0 - off : p0 + off);
    endfunction

    function automatic t_clip clip_segment(t_seg s);
        t_clip       r;
        longint      p0 [3];
        longint      p1 [3];
        longint      bnd, s0, s1;
        logic [TF:0] t_enter, t_leave, t;
        logic        ok;
        int          ax;
        p0[0] = s.sx; p0[1] = s.sy; p0[2] = s.sz;
        p1[0] = s.ex; p1[1] = s.ey; p1[2] = s.ez;
        t_enter = '0;
        t_leave = (TF+1)'(1) << TF;
        ok = 1'b1;
        for (int f = 0; f < 6; f++) begin
            ax  = f >> 1;
            bnd = box_bound[f];
            if ((f & 1) == 0) begin
                s0 = p0[ax] - bnd;
                s1 = p1[ax] - bnd;
            end else begin
                s0 = bnd - p0[ax];
                s1 = bnd - p1[ax];
            end
            if (s0 < 0 && s1 < 0) begin
                ok = 1'b0;
            end else if (s0 < 0) begin
                t = t_ratio(-s0, s1 - s0);
                if (t > t_enter) t_enter = t;
            end else if (s1 < 0) begin
                t = t_ratio(s0, s0 - s1);
                if (t < t_leave) t_leave = t;
            end
        end
        if (t_enter > t_leave) ok = 1'b0;
        r.visible = ok;
        if (ok) begin
            r.sx = point_on(p0[0], p1[0], t_enter);
            r.sy = point_on(p0[1], p1[1], t_enter);
            r.sz = point_on(p0[2], p1[2], t_enter);
            r.ex = point_on(p0[0], p1[0], t_leave);
            r.ey = point_on(p0[1], p1[1], t_leave);
            r.ez = point_on(p0[2], p1[2], t_leave);
        end else begin
            r.sx = s.sx; r.sy = s.sy; r.sz = s.sz;
            r.ex = s.ex; r.ey = s.ey; r.ez = s.ez;
        end
        return r;
    endfunction

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_clip got, want;
        if (i_rst_n && seg_out.valid && seg_out.ready) begin
            got = {seg_out.visible, seg_out.start_x_out, seg_out.start_y_out,
                   seg_out.start_z_out, seg_out.end_x_out, seg_out.end_y_out,
                   seg_out.end_z_out};
            if (clip_expected.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected word %h", got);
            end else begin
                want = clip_expected.pop_front();
                if (got.visible !== want.visible || got.sx !== want.sx ||
                    got.sy !== want.sy || got.sz !== want.sz || got.ex !== want.ex ||
                    got.ey !== want.ey || got.ez !== want.ez) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) begin
                        $write("mismatch exp %0d %0d %0d %0d %0d %0d %0d",
                               want.visible, want.sx, want.sy, want.sz, want.ex,
                               want.ey, want.ez);
                        $display(" got %0d %0d %0d %0d %0d %0d %0d",
                                 got.visible, got.sx, got.sy,
                                 got.sz, got.ex, got.ey, got.ez);
                    end
                end
            end
        end
        seg_out.ready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // ---- drivers ----
    task automatic send_segment(t_seg s);
        t_clip want;
        want = clip_segment(s);
        while ($urandom_range(99) < send_idle_pct) begin
            seg_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg_in.valid      <= 1'b1;
        seg_in.start_x_in <= s.sx;
        seg_in.start_y_in <= s.sy;
        seg_in.start_z_in <= s.sz;
        seg_in.end_x_in   <= s.ex;
        seg_in.end_y_in   <= s.ey;
        seg_in.end_z_in   <= s.ez;
        do @(posedge i_clk); while (!seg_in.ready);
        clip_expected.push_back(want);
    endtask

    task automatic drain_pipe();
        seg_in.valid <= 1'b0;
        wait (clip_expected.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [BLC_IDX_W-1:0] idx, logic signed [W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx <= REG_Z_HIGH) box_bound[idx] = val;
    endtask

    task automatic load_box(logic signed [W-1:0] xl, xh, yl, yh, zl, zh);
        drain_pipe();
        write_reg(REG_X_LOW, xl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_Y_HIGH, yh);
        write_reg(REG_Z_LOW, zl);
        write_reg(REG_Z_HIGH, zh);
        @(posedge i_clk);
    endtask

    function automatic logic signed [W-1:0] near_coord(int ax);
        longint lo, span;
        lo   = box_bound[2*ax];
        span = longint'(box_bound[2*ax+1]) - lo;
        if (span < 1) span = 1;
        return W'(lo - span + longint'({$urandom, $urandom}) % (3 * span + 1)
                  * (longint'({$urandom, $urandom}) < 0 ? -1 : 1) + span);
    endfunction

    function automatic t_seg random_segment();
        t_seg s;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            s = {near_coord(0), near_coord(1), near_coord(2),
                 near_coord(0), near_coord(1), near_coord(2)};
            // parallel to one pair of faces, or a single point
            if (pick < 30) begin
                case ($urandom_range(2))
                    0: s.ex = s.sx;
                    1: s.ey = s.sy;
                    default: s.ez = s.sz;
                endcase
            end else if (pick < 35) begin
                s.ex = s.sx; s.ey = s.sy; s.ez = s.sz;
            end
        end
        return s;
    endfunction

    // ---- tests ----
    localparam logic signed [W-1:0] ONE  = 32'sd65536;
    localparam logic signed [W-1:0] VMAX = 32'sh7fffffff;
    localparam logic signed [W-1:0] VMIN = 32'sh80000000;

    task automatic test_default_box();
        send_segment({ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE});
        send_segment({-ONE, 2*ONE, ONE, 6*ONE, 2*ONE, ONE});
        send_segment({6*ONE, 2*ONE, ONE, -ONE, 3*ONE, 2*ONE});
        send_segment({-ONE, -ONE, -ONE, 6*ONE, 5*ONE, 4*ONE});
        send_segment({ONE, -ONE, ONE, 3*ONE, -ONE, 2*ONE});
        send_segment({ONE, 5*ONE, ONE, 3*ONE, 5*ONE, 2*ONE});
        send_segment({2*ONE, 2*ONE, ONE, 2*ONE, 2*ONE, ONE});
        send_segment({9*ONE, 2*ONE, ONE, 9*ONE, 2*ONE, ONE});
        send_segment({32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
        send_segment({5*ONE, 4*ONE, 3*ONE, 5*ONE, 4*ONE, 3*ONE});
        // touches the box only at its corner: entry equals exit
        send_segment({-ONE, ONE, 32'sd0, ONE, -ONE, 32'sd0});
        send_segment({6*ONE, 5*ONE, ONE, 3*ONE, -ONE, 2*ONE});
        send_segment({-ONE, 2*ONE, ONE, 2*ONE, 9*ONE, ONE});
        send_segment({VMIN, VMIN, VMIN, VMAX, VMAX, VMAX});
        send_segment({VMAX, VMAX, VMAX, VMIN, VMIN, VMIN});
        send_segment({VMIN, 2*ONE, ONE, VMAX, 2*ONE, ONE});
        send_segment({VMAX, VMIN, VMAX, VMAX, VMIN, VMAX});
        send_segment({ONE, ONE, -ONE, ONE, ONE, 9*ONE});
    endtask

    task automatic test_extreme_box();
        load_box(VMIN, VMAX, VMIN, VMAX, VMIN, VMAX);
        write_reg(REG_SPARE, 32'sd12345);
        send_segment({VMIN, VMIN, VMIN, VMAX, VMAX, VMAX});
        send_segment({VMAX, 32'sd0, VMIN, VMIN, 32'sd7, VMAX});
        load_box(VMAX, VMAX, VMIN, VMIN, 32'sd0, 32'sd0);
        send_segment({VMAX, VMIN, 32'sd0, VMAX, VMIN, 32'sd0});
        send_segment({VMIN, VMAX, -ONE, VMAX, VMIN, ONE});
    endtask

    task automatic test_inverted_box();
        load_box(5*ONE, ONE, 32'sd0, 4*ONE, 32'sd0, 3*ONE);
        send_segment({2*ONE, ONE, ONE, 3*ONE, 2*ONE, 2*ONE});
        send_segment({-ONE, ONE, ONE, 9*ONE, 2*ONE, 2*ONE});
    endtask

    task automatic test_random_boxes(int n_items);
        logic signed [W-1:0] lo [3];
        logic signed [W-1:0] hi [3];
        for (int b = 0; b < 6; b++) begin
            for (int ax = 0; ax < 3; ax++) begin
                lo[ax] = $urandom_range(7) == 0 ? $urandom : $signed($urandom) >>> 8;
                hi[ax] = $urandom_range(15) == 0 ? $urandom
                                                 : lo[ax] + ($urandom >> 10);
            end
            load_box(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
            for (int i = 0; i < n_items / 6; i++) begin
                if (b == 2 && i == 40) begin
                    seg_in.valid <= 1'b0;
                    wait (clip_expected.size() == 0);
                    @(posedge i_clk);
                end
                send_segment(random_segment());
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_X_LOW;
        i_cfg_data        <= '0;
        seg_in.valid      <= 1'b0;
        seg_in.start_x_in <= '0;
        seg_in.start_y_in <= '0;
        seg_in.start_z_in <= '0;
        seg_in.end_x_in   <= '0;
        seg_in.end_y_in   <= '0;
        seg_in.end_z_in   <= '0;
        mismatches        = 0;
        cycle_count       = 0;
        send_idle_pct     = 7;
        recv_idle_pct     = 63;
        box_bound[0] = 0;      box_bound[1] = 5 * ONE;
        box_bound[2] = 0;      box_bound[3] = 4 * ONE;
        box_bound[4] = 0;      box_bound[5] = 3 * ONE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_box();
        test_extreme_box();
        test_inverted_box();
        test_random_boxes(600);
        send_idle_pct = 63;
        recv_idle_pct = 7;
        test_random_boxes(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_boxes(600);

        drain_pipe();
        if (mismatches == 0 && clip_expected.size() == 0)
            $display("box_line_clipper_3d_unit verification clean");
        else
            $display("box_line_clipper_3d_unit verification failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/blc_pkg.sv
hw/rtl/blc_in_if.sv
hw/rtl/blc_out_if.sv
hw/rtl/blc_tdiv.sv
hw/rtl/blc_tscale.sv
hw/rtl/box_line_clipper_3d_unit.sv
test/box_line_clipper_3d_unit_test.sv
